// ===== hw/rtl/apt_pkg.sv =====
// shared types and constants of the affine point transform
package apt_pkg;

	// angle units: 1/256 degree
	localparam logic signed [18:0] FULL_TURN    = 19'sd92160;
	localparam logic signed [18:0] HALF_TURN    = 19'sd46080;
	localparam logic signed [18:0] QUARTER_TURN = 19'sd23040;

	localparam int GUARD     = 4;
	localparam int TABLE_LEN = 28;
	localparam int UW        = 38;
	localparam int ADDR_W    = 5;

	localparam longint GAIN_Q30 = 64'sd652032874;

	localparam logic signed [15:0] STRETCH_ONE = 16'sd4096;

	// atan(2^-i) at 2^24 units per degree
	localparam logic signed [31:0] ATAN_DEG24 [TABLE_LEN] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938, 32'sd60000934,
		32'sd30029717, 32'sd15018523, 32'sd7509720, 32'sd3754917, 32'sd1877466,
		32'sd938734, 32'sd469367, 32'sd234684, 32'sd117342, 32'sd58671,
		32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57,
		32'sd29, 32'sd14, 32'sd7
	};

	typedef enum logic [2:0] {
		REG_SHIFT_X    = 3'd0,
		REG_SHIFT_Y    = 3'd1,
		REG_TURN_ANGLE = 3'd2,
		REG_STRETCH_X  = 3'd3,
		REG_STRETCH_Y  = 3'd4
	} apt_reg_t;

	// scaled point and quadrant flag riding along the rotation chain
	typedef struct packed {
		logic                 flip;
		logic signed [UW-1:0] ux;
		logic signed [UW-1:0] uy;
	} apt_carry_t;

endpackage

// ===== hw/rtl/apt_point_if.sv =====
// input point channel
interface apt_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;

	modport source (output valid, point_x, point_y, input ready);
	modport sink (input valid, point_x, point_y, output ready);
endinterface

// ===== hw/rtl/apt_result_if.sv =====
// result point channel
interface apt_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_x;
	logic signed [31:0] result_y;

	modport source (output valid, result_x, result_y, input ready);
	modport sink (input valid, result_x, result_y, output ready);
endinterface

// ===== hw/rtl/apt_cordic_cell.sv =====
// one rotation-mode cordic iteration, registered
module apt_cordic_cell #(
	parameter int XW  = 21,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [XW-1:0]      x,
	input  logic signed [XW-1:0]      y,
	input  logic signed [31:0]        z,
	input  apt_pkg::apt_carry_t       carry,
	output logic signed [XW-1:0]      x_s1,
	output logic signed [XW-1:0]      y_s1,
	output logic signed [31:0]        z_s1,
	output apt_pkg::apt_carry_t       carry_s1
);

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [31:0]   step;

	assign dx   = y >>> IDX;
	assign dy   = x >>> IDX;
	assign step = apt_pkg::ATAN_DEG24[IDX];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z[31]) begin
				x_s1 <= x - dx;
				y_s1 <= y + dy;
				z_s1 <= z - step;
			end else begin
				x_s1 <= x + dx;
				y_s1 <= y - dy;
				z_s1 <= z + step;
			end
			carry_s1 <= carry;
		end
	end

endmodule

// ===== hw/rtl/apt_axis.sv =====
// one output coordinate: ta*ua + tb*ub + shift, rounded and saturated
module apt_axis #(
	parameter int CW = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [CW-1:0]          ta,
	input  logic signed [CW-1:0]          tb,
	input  logic signed [apt_pkg::UW-1:0] ua,
	input  logic signed [apt_pkg::UW-1:0] ub,
	input  logic signed [31:0]            shift,
	output logic signed [31:0]            res_s4
);

	localparam int LB = 19;
	localparam int HB = apt_pkg::UW - LB;
	localparam int SW = CW + 39;
	localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (CW - 1);
	localparam logic signed [SW-1:0] POS_LIM = SW'(signed'(32'h7FFF_FFFF));
	localparam logic signed [SW-1:0] NEG_LIM = SW'(signed'(32'h8000_0000));

	logic signed [HB-1:0]    a_hi, b_hi;
	logic signed [LB:0]      a_lo, b_lo;
	logic signed [CW+HB-1:0] pah_s1, pbh_s1;
	logic signed [CW+LB:0]   pal_s1, pbl_s1;
	logic signed [SW-1:0]    pa_s2, pb_s2;
	logic signed [SW-1:0]    sum_s3;
	logic signed [SW-1:0]    q;

	// split the wide operand so each multiplier stays narrow
	assign a_hi = ua[apt_pkg::UW-1:LB];
	assign b_hi = ub[apt_pkg::UW-1:LB];
	assign a_lo = signed'({1'b0, ua[LB-1:0]});
	assign b_lo = signed'({1'b0, ub[LB-1:0]});
	assign q    = sum_s3 >>> CW;

	always_ff @(posedge clk) begin
		if (en) begin
			pah_s1 <= ta * a_hi;
			pal_s1 <= ta * a_lo;
			pbh_s1 <= tb * b_hi;
			pbl_s1 <= tb * b_lo;
			pa_s2  <= (SW'(pah_s1) <<< LB) + SW'(pal_s1);
			pb_s2  <= (SW'(pbh_s1) <<< LB) + SW'(pbl_s1);
			sum_s3 <= pa_s2 + pb_s2 + (SW'(shift) <<< CW) + HALF;
			if (q > POS_LIM) begin
				res_s4 <= 32'sh7FFF_FFFF;
			end else if (q < NEG_LIM) begin
				res_s4 <= signed'(32'h8000_0000);
			end else begin
				res_s4 <= q[31:0];
			end
		end
	end

endmodule

// ===== hw/rtl/affine_point_transform_2d.sv =====
// top level: scale, rotate and translate a stream of 2d points
//
//  channel   dir  handshake       payload
//  points    in   valid/ready     point_x, point_y   (Q16.16)
//  results   out  valid/ready     result_x, result_y (Q16.16)
//  apb       in   psel/penable    shift, angle, stretch registers
//
// one item per cycle unless the output stalls; the pipeline is one cordic cell
// per iteration plus the entry, trig rounding and four multiply/sum stages.
// every item runs its own cordic in the cell chain.
// a stalled output freezes the whole pipeline; no stage drops or repeats.
// reset clears the valid line and loads the register reset values.
module affine_point_transform_2d #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	apt_point_if.sink                   points,
	apt_result_if.source                results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [apt_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int F     = TRIG_FRAC_BITS;
	localparam int G     = F + apt_pkg::GUARD;
	localparam int XW    = G + 3;
	localparam int CW    = F + 2;
	localparam int NCELL = (F + 2 > apt_pkg::TABLE_LEN) ? apt_pkg::TABLE_LEN : F + 2;
	localparam int DEPTH = NCELL + 6;
	localparam longint GAIN_R = (apt_pkg::GAIN_Q30 + (longint'(1) << (29 - G))) >>> (30 - G);
	localparam logic signed [XW-1:0] X_INIT = XW'(GAIN_R);
	localparam logic signed [XW-1:0] RND_T  = XW'(1 << (apt_pkg::GUARD - 1));
	localparam logic signed [XW-1:0] LIM_T  = XW'(1 << F);
	localparam logic signed [CW-1:0] LIM_C  = CW'(1 << F);

	// configuration registers
	logic signed [31:0] shift_x_q, shift_y_q;
	logic signed [17:0] turn_angle_q;
	logic signed [15:0] stretch_x_q, stretch_y_q;
	apt_pkg::apt_reg_t  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = apt_pkg::apt_reg_t'(paddr[apt_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q    <= '0;
			shift_y_q    <= '0;
			turn_angle_q <= '0;
			stretch_x_q  <= apt_pkg::STRETCH_ONE;
			stretch_y_q  <= apt_pkg::STRETCH_ONE;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				apt_pkg::REG_SHIFT_X:    shift_x_q    <= pwdata;
				apt_pkg::REG_SHIFT_Y:    shift_y_q    <= pwdata;
				apt_pkg::REG_TURN_ANGLE: turn_angle_q <= pwdata[17:0];
				apt_pkg::REG_STRETCH_X:  stretch_x_q  <= pwdata[15:0];
				apt_pkg::REG_STRETCH_Y:  stretch_y_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			apt_pkg::REG_SHIFT_X:    prdata = shift_x_q;
			apt_pkg::REG_SHIFT_Y:    prdata = shift_y_q;
			apt_pkg::REG_TURN_ANGLE: prdata = {14'd0, turn_angle_q};
			apt_pkg::REG_STRETCH_X:  prdata = {16'd0, stretch_x_q};
			apt_pkg::REG_STRETCH_Y:  prdata = {16'd0, stretch_y_q};
			default:                 prdata = '0;
		endcase
	end

	// pipeline control
	logic [DEPTH-1:0] valid_q;
	logic             adv;

	assign adv           = !valid_q[DEPTH-1] || results.ready;
	assign points.ready  = adv;
	assign results.valid = valid_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[DEPTH-2:0], points.valid};
		end
	end

	// entry: angle reduction and per-axis scaling
	logic signed [18:0] ang0, ang1, ang2, ang3;
	logic               flip;
	logic signed [47:0] prod_x, prod_y;
	logic signed [47:0] rnd_x, rnd_y;

	always_comb begin
		ang0 = 19'(turn_angle_q);
		if (ang0 >= apt_pkg::FULL_TURN) begin
			ang1 = ang0 - apt_pkg::FULL_TURN;
		end else if (ang0 <= -apt_pkg::FULL_TURN) begin
			ang1 = ang0 + apt_pkg::FULL_TURN;
		end else begin
			ang1 = ang0;
		end
		if (ang1 >= apt_pkg::HALF_TURN) begin
			ang2 = ang1 - apt_pkg::FULL_TURN;
		end else if (ang1 < -apt_pkg::HALF_TURN) begin
			ang2 = ang1 + apt_pkg::FULL_TURN;
		end else begin
			ang2 = ang1;
		end
		// fold into +-90 degrees, negate cos and sin at the end
		flip = 1'b1;
		if (ang2 > apt_pkg::QUARTER_TURN) begin
			ang3 = ang2 - apt_pkg::HALF_TURN;
		end else if (ang2 < -apt_pkg::QUARTER_TURN) begin
			ang3 = ang2 + apt_pkg::HALF_TURN;
		end else begin
			ang3 = ang2;
			flip = 1'b0;
		end
	end

	assign prod_x = stretch_x_q * points.point_x;
	assign prod_y = stretch_y_q * points.point_y;
	assign rnd_x  = (prod_x + 48'sd512) >>> 10;
	assign rnd_y  = (prod_y + 48'sd512) >>> 10;

	logic signed [31:0]  z_s1;
	apt_pkg::apt_carry_t carry_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s1           <= 32'(ang3) <<< 16;
			carry_s1.flip  <= flip;
			carry_s1.ux    <= rnd_x[apt_pkg::UW-1:0];
			carry_s1.uy    <= rnd_y[apt_pkg::UW-1:0];
		end
	end

	// cordic cell chain
	logic signed [XW-1:0] cx [NCELL+1];
	logic signed [XW-1:0] cy [NCELL+1];
	logic signed [31:0]   cz [NCELL+1];
	apt_pkg::apt_carry_t  ck [NCELL+1];

	assign cx[0] = X_INIT;
	assign cy[0] = '0;
	assign cz[0] = z_s1;
	assign ck[0] = carry_s1;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		apt_cordic_cell #(
			.XW  (XW),
			.IDX (k)
		) u_cell (
			.clk      (clk),
			.en       (adv),
			.x        (cx[k]),
			.y        (cy[k]),
			.z        (cz[k]),
			.carry    (ck[k]),
			.x_s1     (cx[k+1]),
			.y_s1     (cy[k+1]),
			.z_s1     (cz[k+1]),
			.carry_s1 (ck[k+1])
		);
	end

	// round cos and sin to F fraction bits, clamp, undo the fold
	logic signed [XW-1:0] x_rnd, y_rnd, x_sh, y_sh;
	logic signed [CW-1:0] c_cl, s_cl, c_fin, s_fin;
	logic signed [CW-1:0] c_s2, s_s2, ns_s2;
	logic signed [apt_pkg::UW-1:0] ux_s2, uy_s2;

	assign x_rnd = cx[NCELL] + RND_T;
	assign y_rnd = cy[NCELL] + RND_T;
	assign x_sh  = x_rnd >>> apt_pkg::GUARD;
	assign y_sh  = y_rnd >>> apt_pkg::GUARD;

	always_comb begin
		if (x_sh > LIM_T) begin
			c_cl = LIM_C;
		end else if (x_sh < -LIM_T) begin
			c_cl = -LIM_C;
		end else begin
			c_cl = x_sh[CW-1:0];
		end
		if (y_sh > LIM_T) begin
			s_cl = LIM_C;
		end else if (y_sh < -LIM_T) begin
			s_cl = -LIM_C;
		end else begin
			s_cl = y_sh[CW-1:0];
		end
		c_fin = ck[NCELL].flip ? -c_cl : c_cl;
		s_fin = ck[NCELL].flip ? -s_cl : s_cl;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2  <= c_fin;
			s_s2  <= s_fin;
			ns_s2 <= -s_fin;
			ux_s2 <= ck[NCELL].ux;
			uy_s2 <= ck[NCELL].uy;
		end
	end

	// x' = shift_x + cos*ux - sin*uy, y' = shift_y + sin*ux + cos*uy
	apt_axis #(
		.CW (CW)
	) u_axis_x (
		.clk    (clk),
		.en     (adv),
		.ta     (c_s2),
		.tb     (ns_s2),
		.ua     (ux_s2),
		.ub     (uy_s2),
		.shift  (shift_x_q),
		.res_s4 (results.result_x)
	);

	apt_axis #(
		.CW (CW)
	) u_axis_y (
		.clk    (clk),
		.en     (adv),
		.ta     (s_s2),
		.tb     (c_s2),
		.ua     (ux_s2),
		.ub     (uy_s2),
		.shift  (shift_y_q),
		.res_s4 (results.result_y)
	);

	// input is held off only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!points.ready |-> results.valid)
		else $error("input stalled with no result waiting");

	// trig values stay within one after clamping
	a_trig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[NCELL+1] |-> (c_s2 <= LIM_C && c_s2 >= -LIM_C &&
			s_s2 <= LIM_C && s_s2 >= -LIM_C))
		else $error("cos or sin out of range");

	// a held result freezes the valid line
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> valid_q == $past(valid_q))
		else $error("pipeline moved during output stall");

endmodule

// ===== tb/sv/apt_checker.sv =====
// checker: tracks register writes, predicts each transformed point and compares results
module apt_checker #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	apt_point_if                       points,
	apt_result_if                      results,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [apt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output int                         fail_count,
	output int                         pending,
	output int                         matched
);
	import apt_pkg::*;

	localparam int ITERS  = (TRIG_FRAC_BITS + 2 > TABLE_LEN) ? TABLE_LEN : TRIG_FRAC_BITS + 2;
	localparam int PATH_F = TRIG_FRAC_BITS + GUARD;
	localparam int SUM_SH = TRIG_FRAC_BITS + 2;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} xy_t;

	logic signed [31:0] shift_x, shift_y;
	logic signed [17:0] turn;
	logic signed [15:0] stretch_x, stretch_y;
	xy_t awaited_points[$];
	int fails = 0;
	int hits = 0;

	assign fail_count = fails;
	assign pending    = awaited_points.size();
	assign matched    = hits;

	// cos/sin of the turn angle at TRIG_FRAC_BITS fraction bits
	function automatic void turn_trig(input logic signed [17:0] ang, output longint c,
			output longint s);
		longint a, x, y, z, dx, dy, lim;
		logic flip;
		int i;
		a = longint'(ang) % longint'(FULL_TURN);
		flip = 1'b0;
		if (a >= HALF_TURN) a -= FULL_TURN;
		if (a < -HALF_TURN) a += FULL_TURN;
		if (a > QUARTER_TURN) begin
			a -= HALF_TURN;
			flip = 1'b1;
		end else if (a < -QUARTER_TURN) begin
			a += HALF_TURN;
			flip = 1'b1;
		end
		x = (GAIN_Q30 + (longint'(1) <<< (29 - PATH_F))) >>> (30 - PATH_F);
		y = 0;
		z = a * 65536;
		for (i = 0; i < ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_DEG24[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_DEG24[i];
			end
		end
		lim = longint'(1) <<< TRIG_FRAC_BITS;
		c = (x + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
		s = (y + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
		if (c > lim) c = lim;
		if (c < -lim) c = -lim;
		if (s > lim) s = lim;
		if (s < -lim) s = -lim;
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	// Q4.12 times Q16.16, rounded to Q.18
	function automatic longint scale_coord(input logic signed [15:0] k,
			input logic signed [31:0] p);
		return (longint'(k) * longint'(p) + 512) >>> 10;
	endfunction

	function automatic logic signed [31:0] round_sat(input logic signed [31:0] sh,
			input longint acc);
		longint v;
		v = (longint'(sh) <<< SUM_SH) + acc;
		v = (v + (longint'(1) <<< (SUM_SH - 1))) >>> SUM_SH;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic xy_t transform_point(input xy_t p);
		longint c, s, ux, uy;
		xy_t r;
		turn_trig(turn, c, s);
		ux = scale_coord(stretch_x, p.x);
		uy = scale_coord(stretch_y, p.y);
		r.x = round_sat(shift_x, c * ux - s * uy);
		r.y = round_sat(shift_y, s * ux + c * uy);
		return r;
	endfunction

	task automatic report_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		fails++;
		$display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
			$time, name, want, want, got, got);
	endtask

	always @(posedge clk) begin
		xy_t want, got;
		if (!arst_n) begin
			shift_x   = '0;
			shift_y   = '0;
			turn      = '0;
			stretch_x = STRETCH_ONE;
			stretch_y = STRETCH_ONE;
			awaited_points.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_SHIFT_X:    shift_x   = pwdata;
					REG_SHIFT_Y:    shift_y   = pwdata;
					REG_TURN_ANGLE: turn      = pwdata[17:0];
					REG_STRETCH_X:  stretch_x = pwdata[15:0];
					REG_STRETCH_Y:  stretch_y = pwdata[15:0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				got.x = results.result_x;
				got.y = results.result_y;
				if (awaited_points.size() == 0) begin
					fails++;
					$display("%0t: result (%0d, %0d) with no point outstanding",
						$time, got.x, got.y);
				end else begin
					want = awaited_points.pop_front();
					if (want.x !== got.x) report_field("result_x", want.x, got.x);
					if (want.y !== got.y) report_field("result_y", want.y, got.y);
					if (want === got) hits++;
				end
			end
			if (points.valid && points.ready) begin
				got.x = points.point_x;
				got.y = points.point_y;
				awaited_points.push_back(transform_point(got));
			end
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: clock, reset, point stimulus, register writes and the verdict
module tb_top;
	import apt_pkg::*;

	localparam int F            = 14;
	localparam int CLK_PERIOD   = 12;
	localparam int DRAIN_CYCLES = F + 16;
	localparam int RANDOM_ITEMS = 1450;
	localparam int HOLD_CYCLES  = 150;
	localparam int LIMIT_CYCLES = 200000;
	localparam int REG_COUNT    = 5;

	localparam logic [31:0] CORNERS[7] = '{
		32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff,
		32'h00000001, 32'h00008000, 32'h00010000
	};
	localparam logic [15:0] STRETCH_EDGES[5] = '{
		16'h7fff, 16'h8000, 16'h0000, 16'h1000, 16'hf000
	};

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	int fail_count, pending, matched;
	int sent = 0;
	int settings = 0;
	bit steady = 1'b0;
	int hold_req = 0;

	apt_point_if  points_ch();
	apt_result_if results_ch();

	affine_point_transform_2d #(.TRIG_FRAC_BITS(F)) dut (
		.clk, .arst_n, .points(points_ch), .results(results_ch),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	apt_checker #(.TRIG_FRAC_BITS(F)) point_check (
		.clk, .arst_n, .points(points_ch), .results(results_ch),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending, .matched
	);

	initial clk = 1'b0;
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] reg_addr(input apt_reg_t r);
		return ADDR_W'(int'(r) << 2);
	endfunction

	function automatic logic [31:0] random_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5:       return 32'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
			6:          return 32'(int'($urandom_range(0, 2 ** 27)) - 2 ** 26);
			7:          return 32'h7fffffff - $urandom_range(0, 4095);
			8:          return 32'h80000000 + $urandom_range(0, 4095);
			default:    return CORNERS[$urandom_range(0, 6)];
		endcase
	endfunction

	function automatic logic [31:0] random_shift();
		case ($urandom_range(0, 3))
			0, 1:    return $urandom();
			2:       return 32'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
			default: return CORNERS[$urandom_range(0, 3)];
		endcase
	endfunction

	function automatic logic [15:0] random_stretch();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom());
			1:       return STRETCH_EDGES[$urandom_range(0, 4)];
			2:       return 16'(int'($urandom_range(0, 1024)) + 3584);
			default: return 16'(int'($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	// setup then access; the bus stays selected so writes run back to back
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// upper data bits of the narrow registers carry junk on purpose
	task automatic set_config(input logic [31:0] sx, input logic [31:0] sy,
			input logic [17:0] ang, input logic [15:0] kx, input logic [15:0] ky,
			input bit stray);
		apb_write(reg_addr(REG_SHIFT_X), sx);
		apb_write(reg_addr(REG_SHIFT_Y), sy);
		apb_write(reg_addr(REG_TURN_ANGLE), {14'($urandom()), ang});
		apb_write(reg_addr(REG_STRETCH_X), {16'($urandom()), kx});
		apb_write(reg_addr(REG_STRETCH_Y), {16'($urandom()), ky});
		if (stray)
			apb_write(ADDR_W'((REG_COUNT + $urandom_range(0, 2)) << 2), $urandom());
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y);
		while (!steady && $urandom_range(0, 99) < 6) begin
			points_ch.valid <= 1'b0;
			@(posedge clk);
		end
		points_ch.valid   <= 1'b1;
		points_ch.point_x <= x;
		points_ch.point_y <= y;
		do @(posedge clk); while (!points_ch.ready);
		sent++;
	endtask

	// wait for every outstanding result, then let the pipeline run empty
	task automatic settle();
		points_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_corner_points();
		send_point(32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000);
		send_point(32'h7fffffff, 32'h80000000);
	endtask

	// result side: random stalls, a steady stretch and one long hold-off
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if (hold != 0) begin
				results_ch.ready <= 1'b0;
				hold--;
			end else if (steady) begin
				results_ch.ready <= 1'b1;
			end else begin
				results_ch.ready <= ($urandom_range(0, 99) >= 6);
			end
		end
	end

	initial begin
		int random_sent, phase, count, ang;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		points_ch.valid   = 1'b0;
		points_ch.point_x = '0;
		points_ch.point_y = '0;
		results_ch.ready  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: unit scale, no turn, no shift, with rounding halves
		send_point(32'h00000000, 32'h00000000);
		send_point(32'h7fffffff, 32'h80000000);
		send_point(32'h80000000, 32'h7fffffff);
		send_point(32'h00000001, 32'hffffffff);
		send_point(32'h00008000, 32'hffff8000);
		send_point(32'hffffffff, 32'hffffffff);
		settle();

		// register extremes, angles past a full turn, exact quarter and half turns
		set_config(32'h7fffffff, 32'h80000000, 18'h1ffff, 16'h7fff, 16'h8000, 1'b1);
		send_corner_points();
		settle();
		set_config(32'h80000000, 32'h7fffffff, 18'h20000, 16'h8000, 16'h7fff, 1'b1);
		send_corner_points();
		settle();
		set_config(32'h00000000, 32'h00000000, 18'(23040), 16'h0000, 16'h1000, 1'b0);
		send_corner_points();
		settle();
		set_config(32'h00010000, 32'hffff0000, 18'(46080), 16'h1000, 16'hf000, 1'b0);
		send_corner_points();
		settle();
		set_config(32'hffffffff, 32'h00000001, 18'(-23041), 16'h4000, 16'h0001, 1'b0);
		send_corner_points();
		settle();
		set_config(32'h12345678, 32'hedcba988, 18'(92160), 16'h1000, 16'h1000, 1'b1);
		send_corner_points();
		settle();

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0: set_config(32'h7fffffff, 32'h7fffffff, 18'h0, 16'h7fff, 16'h7fff, 1'b0);
				1: set_config(32'h80000000, 32'h80000000, 18'(46080), 16'h8000, 16'h8000,
					1'b0);
				default: begin
					case ($urandom_range(0, 3))
						0:       ang = int'($urandom_range(0, 262143)) - 131072;
						1:       ang = int'($urandom_range(0, 184320)) - 92160;
						2:       ang = (int'($urandom_range(0, 10)) - 5) * 23040
							+ int'($urandom_range(0, 2)) - 1;
						default: ang = int'($urandom_range(0, 5120)) - 2560;
					endcase
					set_config(random_shift(), random_shift(), 18'(ang), random_stretch(),
						random_stretch(), $urandom_range(0, 3) == 0);
				end
			endcase
			steady = (phase == 2);
			if (phase == 3) hold_req = HOLD_CYCLES;
			count = $urandom_range(70, 140);
			if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
			repeat (count) begin
				send_point(random_coord(), random_coord());
				random_sent++;
			end
			settle();
			steady = 1'b0;
			phase++;
		end

		$display("%0d points sent under %0d register settings, %0d results matched",
			sent, settings, matched);
		$display("covered quarter/half/full turns, wrapped angles, saturation, stray writes");
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results outstanding", pending);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/apt_pkg.sv
hw/rtl/apt_point_if.sv
hw/rtl/apt_result_if.sv
hw/rtl/apt_cordic_cell.sv
hw/rtl/apt_axis.sv
hw/rtl/affine_point_transform_2d.sv
tb/sv/apt_checker.sv
tb/sv/tb_top.sv
